FILE: design/cqp_pkg.sv
package cqp_pkg;

	// defaults for the top level parameters
	localparam int DEPTH_DEF     = 64;
	localparam int WORD_BITS_DEF = 32;

	// count and capacity fields are seven bits wide
	localparam int CNT_W     = 7;
	localparam int CAP_RESET = 64;

	// operation selector
	typedef enum logic [1:0] {
		FUNC_ENQ = 2'd0,
		FUNC_DEQ = 2'd1,
		FUNC_PKO = 2'd2,
		FUNC_PKN = 2'd3
	} func_t;

	// per-beat status handed from the pointer logic to the result stage
	typedef struct packed {
		logic             ok;
		logic             rd;
		logic             full;
		logic             empty;
		logic [CNT_W-1:0] count;
	} res_info_t;

endpackage

FILE: design/cqp_mem.sv
module cqp_mem import cqp_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	parameter int IDX_W     = $clog2(DEPTH)
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [IDX_W-1:0]     raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read data held while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: design/cqp_ctrl.sv
module cqp_ctrl import cqp_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_data,
	input  logic             acc,
	input  func_t            func,
	output res_info_t        info,
	output logic             mem_we,
	output logic [IDX_W-1:0] mem_waddr,
	output logic             mem_re,
	output logic [IDX_W-1:0] mem_raddr
);

	localparam logic [CNT_W-1:0] CAP_INIT = CNT_W'((DEPTH < CAP_RESET) ? DEPTH : CAP_RESET);

	logic [CNT_W-1:0] cap_q, cnt_q, head_q, tail_q;
	logic [CNT_W-1:0] cnt_nx, head_nx, tail_nx, last_idx, rd_idx, cap_wr;
	logic             is_enq, is_full, is_empty, op_ok;

	function automatic logic [CNT_W-1:0] adv(input logic [CNT_W-1:0] idx,
	                                         input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] n;
		n = idx + 1'b1;
		return (n >= cap) ? '0 : n;
	endfunction

	always_comb begin
		is_enq   = (func == FUNC_ENQ);
		is_full  = (cnt_q == cap_q);
		is_empty = (cnt_q == '0);
		op_ok    = is_enq ? !is_full : !is_empty;
		cnt_nx   = cnt_q;
		head_nx  = head_q;
		tail_nx  = tail_q;
		case (func)
			FUNC_ENQ: begin
				if (op_ok) begin
					tail_nx = adv(tail_q, cap_q);
					cnt_nx  = cnt_q + 1'b1;
				end
			end
			FUNC_DEQ: begin
				if (op_ok) begin
					head_nx = adv(head_q, cap_q);
					cnt_nx  = cnt_q - 1'b1;
				end
			end
			default: ;
		endcase
		last_idx = (tail_q == '0) ? cap_q - 1'b1 : tail_q - 1'b1;
		rd_idx   = (func == FUNC_PKN) ? last_idx : head_q;
	end

	assign mem_we    = acc && op_ok && is_enq;
	assign mem_waddr = IDX_W'(tail_q);
	assign mem_re    = acc && op_ok && !is_enq;
	assign mem_raddr = IDX_W'(rd_idx);

	assign info.ok    = op_ok;
	assign info.rd    = op_ok && !is_enq;
	assign info.full  = (cnt_nx == cap_q);
	assign info.empty = (cnt_nx == '0);
	assign info.count = cnt_nx;

	// zero reads as one, anything beyond the store as the store size
	assign cap_wr = (cfg_data == '0) ? CNT_W'(1) :
	                (int'(cfg_data) > DEPTH) ? CNT_W'(DEPTH) : cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= CAP_INIT;
			cnt_q  <= '0;
			head_q <= '0;
			tail_q <= '0;
		end else if (cfg_we && is_empty) begin
			cap_q  <= cap_wr;
			head_q <= '0;
			tail_q <= '0;
		end else if (acc) begin
			cnt_q  <= cnt_nx;
			head_q <= head_nx;
			tail_q <= tail_nx;
		end
	end

`ifndef SYNTHESIS
	a_cnt_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= cap_q)
		else $error("entry count above capacity");

	a_ptr_in_cap: assert property (@(posedge clk) disable iff (!arst_n)
		head_q < cap_q && tail_q < cap_q)
		else $error("pointer outside capacity");

	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		acc && !cfg_we && is_enq && op_ok |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("enqueue did not bump count");
`endif

endmodule

FILE: design/circular_queue_with_peek.sv
// Channel  Dir  Fields (lowest bit first)
// s_*      in   tuser: func[1:0]; tdata: data_in
// m_*      out  tdata: ok, data_out, full_res, empty_res, count
// cfg_*    in   cfg_data: capacity, taken while cfg_we is high and the queue is empty
//
// One beat per cycle sustained while m_tready stays high; a result shows on m_tvalid once its
// input beat has passed the issue stage (store read and status) and then the result register.
// Reset zeroes head, tail and count and sets capacity to min(64, DEPTH);
// store contents are not cleared, no clearing pass.
// With m_tready low the result register holds, one more beat waits in the
// issue stage, then s_tready drops.
module circular_queue_with_peek import cqp_pkg::*; #(
	parameter int DEPTH     = DEPTH_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF,
	localparam int IN_TW    = ((WORD_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = WORD_BITS + 3 + CNT_W,
	localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CNT_W-1:0]      cfg_data,  // capacity
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_TW-1:0]      s_tdata,   // data_in, zero pad
	input  logic [1:0]            s_tuser,   // func
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_TW-1:0]     m_tdata    // ok, data_out, full_res, empty_res, count, pad
);

	localparam int IDX_W    = $clog2(DEPTH);

	logic                 acc, adv_s1;
	res_info_t            iss, info_s1;
	logic                 v_s1, out_v_q;
	logic                 mem_we, mem_re;
	logic [IDX_W-1:0]     mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] rdata, dout;
	logic [OUT_TW-1:0]    out_q;

	// issue stage moves on when the result register is free or draining
	assign adv_s1   = !out_v_q || m_tready;
	assign s_tready = !v_s1 || adv_s1;
	assign acc      = s_tvalid && s_tready;

	cqp_ctrl #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.acc       (acc),
		.func      (func_t'(s_tuser)),
		.info      (iss),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr)
	);

	cqp_mem #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS),
		.IDX_W     (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (s_tdata[WORD_BITS-1:0]),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (rdata)
	);

	// issue stage: status travels alongside the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv_s1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			info_s1 <= iss;
		end
	end

	// enqueues and failed beats report a zero word
	assign dout = info_s1.rd ? rdata : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv_s1) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && v_s1) begin
			out_q <= OUT_TW'({info_s1.count, info_s1.empty, info_s1.full, dout,
			                  info_s1.ok});
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

`ifndef SYNTHESIS
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_v_q && !m_tready |-> !s_tready)
		else $error("input taken with both stages blocked");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[WORD_BITS:1] == '0)
		else $error("failed beat carries a word");
`endif

endmodule
